### rtl/esa_pkg.sv
// Shared types and constants for the expert load scatter accumulator.
// No dependencies; used by esa_core and the top level.
package esa_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned DeltaW = 33;
  localparam int unsigned TotalW = 64;
  localparam int unsigned LayerW = 6;
  localparam int unsigned ExpertW = 8;
  localparam int unsigned SlotW = 4;

  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  // One input beat as seen by the core
  typedef struct packed {
    logic [1:0]         cmd;
    logic [LayerW-1:0]  layer;
    logic [SlotW-1:0]   slot;
    logic [ExpertW-1:0] expert_id;
    logic [CountW-1:0]  cumulative_count;
    logic [TotalW-1:0]  write_value;
  } item_t;

  typedef struct packed {
    logic [DeltaW-1:0] slot_delta;
    logic [TotalW-1:0] expert_total;
  } result_t;

endpackage

### rtl/esa_mem.sv
// Load table storage: one write port, one read port, registered read data.
// No package dependencies; instantiated by the top level.
module esa_mem #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14,
  parameter int unsigned W     = 64
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/esa_core.sv
// Control for the load table: clearing sweep, read-modify-write sequencer,
// slot delta and previous counter. Depends on esa_pkg.
module esa_core #(
  parameter int unsigned LAYERS  = 64,
  parameter int unsigned EXPERTS = 256,
  parameter int unsigned DEPTH   = 16384,
  parameter int unsigned AW      = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             item_valid_i,
  output logic                             item_ready_o,
  input  esa_pkg::item_t                   item_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output esa_pkg::result_t                 res_o,
  output logic                             mem_we_o,
  output logic [AW-1:0]                    mem_waddr_o,
  output logic [esa_pkg::TotalW-1:0]       mem_wdata_o,
  output logic                             mem_re_o,
  output logic [AW-1:0]                    mem_raddr_o,
  input  logic [esa_pkg::TotalW-1:0]       mem_rdata_i
);

  esa_pkg::state_e state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [esa_pkg::CountW-1:0] prev_q, prev_d;

  // Held beat while the table read is outstanding
  esa_pkg::item_t item_q;
  logic           ok_q;
  logic [AW-1:0]  addr_q;

  logic          in_ok;
  logic [AW-1:0] in_addr;
  logic          accept;
  logic          done;

  logic [esa_pkg::DeltaW-1:0] delta;
  logic [esa_pkg::TotalW-1:0] total;
  logic                       wr_en;

  assign in_ok = (32'(item_i.layer) < 32'(LAYERS)) && (32'(item_i.expert_id) < 32'(EXPERTS));
  assign in_addr = AW'(AW'(item_i.layer) * AW'(EXPERTS)) + AW'(item_i.expert_id);

  assign item_ready_o = (state_q == esa_pkg::ST_IDLE);
  assign accept = item_valid_i && item_ready_o;
  assign res_valid_o = (state_q == esa_pkg::ST_EXEC);
  assign done = res_valid_o && res_ready_i;

  always_comb begin
    delta = '0;
    total = '0;
    wr_en = 1'b0;
    prev_d = prev_q;
    unique case (esa_pkg::cmd_e'(item_q.cmd))
      esa_pkg::CMD_ACC: begin
        if (item_q.slot == '0) begin
          delta = {1'b0, item_q.cumulative_count};
        end else begin
          delta = {1'b0, item_q.cumulative_count} - {1'b0, prev_q};
        end
        prev_d = item_q.cumulative_count;
        if (ok_q) begin
          total = mem_rdata_i + {{(esa_pkg::TotalW - esa_pkg::DeltaW){delta[esa_pkg::DeltaW-1]}},
                                 delta};
          wr_en = 1'b1;
        end
      end
      esa_pkg::CMD_READ: begin
        if (ok_q) begin
          total = mem_rdata_i;
        end
      end
      esa_pkg::CMD_WRITE: begin
        if (ok_q) begin
          total = item_q.write_value;
          wr_en = 1'b1;
        end
      end
      default: begin
        // unused command: no state change, zero result
      end
    endcase
  end

  assign res_o.slot_delta   = delta;
  assign res_o.expert_total = total;

  always_comb begin
    state_d = state_q;
    clr_cnt_d = clr_cnt_q;
    mem_we_o = 1'b0;
    mem_waddr_o = addr_q;
    mem_wdata_o = total;
    unique case (state_q)
      esa_pkg::ST_CLEAR: begin
        mem_we_o = 1'b1;
        mem_waddr_o = clr_cnt_q;
        mem_wdata_o = '0;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = esa_pkg::ST_IDLE;
        end
      end
      esa_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = esa_pkg::ST_EXEC;
        end
      end
      esa_pkg::ST_EXEC: begin
        if (done) begin
          mem_we_o = wr_en;
          state_d = esa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = esa_pkg::ST_CLEAR;
      end
    endcase
  end

  assign mem_re_o = accept;
  assign mem_raddr_o = in_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= esa_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
      prev_q <= '0;
    end else begin
      state_q <= state_d;
      clr_cnt_q <= clr_cnt_d;
      if (done) begin
        prev_q <= prev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
      ok_q <= in_ok;
      addr_q <= in_addr;
    end
  end

endmodule

### rtl/expert_load_scatter_accumulator_top.sv
// Top level of the expert load scatter accumulator: stream ports, output
// register, table memory and core. Depends on esa_pkg, esa_mem, esa_core.

// After reset the block sweeps the load table to zero, one entry a cycle,
// over all LAYERS*EXPERTS entries (16384 at the defaults), taking no beat
// until the sweep ends. Then each beat goes through the registered read of
// its table entry, then forming the result and writing the entry back once
// the output register takes it; no new beat is accepted before that. The
// output register holds a finished result while the next beat is already read.
module expert_load_scatter_accumulator_top #(
  parameter int unsigned LAYERS  = 64,
  parameter int unsigned EXPERTS = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // layer[5:0], device[9:6], slot[13:10], expert_id[21:14],
  // cumulative_count[53:22], write_value[117:54], zero pad [119:118]
  input  logic [119:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // slot_delta[32:0], expert_total[96:33], zero pad [103:97]
  output logic [103:0] m_axis_tdata
);

  localparam int unsigned Depth = LAYERS * EXPERTS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  esa_pkg::item_t   item;
  esa_pkg::result_t res;
  logic             res_valid;
  logic             res_ready;

  logic                        mem_we;
  logic [AddrW-1:0]            mem_waddr;
  logic [esa_pkg::TotalW-1:0]  mem_wdata;
  logic                        mem_re;
  logic [AddrW-1:0]            mem_raddr;
  logic [esa_pkg::TotalW-1:0]  mem_rdata;

  logic         m_valid_q;
  logic [103:0] m_data_q;

  // device takes no part in the result
  assign item.cmd              = s_axis_tuser;
  assign item.layer            = s_axis_tdata[5:0];
  assign item.slot             = s_axis_tdata[13:10];
  assign item.expert_id        = s_axis_tdata[21:14];
  assign item.cumulative_count = s_axis_tdata[53:22];
  assign item.write_value      = s_axis_tdata[117:54];

  esa_core #(
    .LAYERS  (LAYERS),
    .EXPERTS (EXPERTS),
    .DEPTH   (Depth),
    .AW      (AddrW)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  esa_mem #(
    .DEPTH (Depth),
    .AW    (AddrW),
    .W     (esa_pkg::TotalW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_data_q <= {7'd0, res.expert_total, res.slot_delta};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
